// ===== rtl/core/neighbor_table_update_purge_top_defines.svh =====
// assertion macros for the neighbour table block
`ifndef NEIGHBOR_TABLE_UPDATE_PURGE_TOP_DEFINES_SVH
`define NEIGHBOR_TABLE_UPDATE_PURGE_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
// consequent checked in the same cycle as the antecedent
`define NTUP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// consequent checked in the cycle after the antecedent
`define NTUP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NTUP_ASSERT_NOW(lbl, ante, cons, msg)
`define NTUP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/core/ntup_pkg.sv =====
// types and constants shared by the neighbour table block
`default_nettype none
package ntup_pkg;

    typedef enum logic [1:0] {
        OP_MSG   = 2'd0,
        OP_PURGE = 2'd1,
        OP_READ  = 2'd2
    } t_op;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE = 2'd1;

    localparam logic [7:0] CUTOFF_RST  = 8'd100;
    localparam logic [7:0] MAX_AGE_RST = 8'd64;

    typedef struct packed {
        logic [15:0] id;
        logic [31:0] stamp;
        logic [7:0]  distance;
        logic [7:0]  sender_count;
        logic [15:0] gradient;
        logic [15:0] follower;
        logic [7:0]  grp;
    } t_entry;

    typedef struct packed {
        logic [3:0]  entry_count;
        logic        stored;
        logic [3:0]  removed_count;
        logic        read_valid;
        logic [15:0] read_id;
        logic [7:0]  read_distance;
        logic [7:0]  read_sender_count;
        logic [15:0] read_gradient;
        logic [15:0] read_follower;
        logic [7:0]  read_group;
        logic [31:0] read_stamp;
    } t_rsp;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } t_mem_ctl;

    typedef struct packed {
        logic busy;
        logic fin;
    } t_ctl_stat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_PURGE_RD,
        S_PURGE_CHK,
        S_PURGE_MV,
        S_READ_RD,
        S_FIN
    } t_state;

endpackage
`default_nettype wire

// ===== rtl/core/ntup_in_if.sv =====
// request channel of the neighbour table
`default_nettype none
interface ntup_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [15:0] sender_id;
    logic [7:0]  distance;
    logic [7:0]  sender_count;
    logic [15:0] gradient;
    logic [15:0] follower;
    logic [7:0]  group_byte;
    logic [31:0] now;
    logic [3:0]  slot_index;

    modport source (
        output valid, op, sender_id, distance, sender_count, gradient, follower,
               group_byte, now, slot_index,
        input  ready
    );
    modport sink (
        input  valid, op, sender_id, distance, sender_count, gradient, follower,
               group_byte, now, slot_index,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/ntup_out_if.sv =====
// response channel of the neighbour table
`default_nettype none
interface ntup_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  entry_count;
    logic        stored;
    logic [3:0]  removed_count;
    logic        read_valid;
    logic [15:0] read_id;
    logic [7:0]  read_distance;
    logic [7:0]  read_sender_count;
    logic [15:0] read_gradient;
    logic [15:0] read_follower;
    logic [7:0]  read_group;
    logic [31:0] read_stamp;

    modport source (
        output valid, entry_count, stored, removed_count, read_valid, read_id,
               read_distance, read_sender_count, read_gradient, read_follower,
               read_group, read_stamp,
        input  ready
    );
    modport sink (
        input  valid, entry_count, stored, removed_count, read_valid, read_id,
               read_distance, read_sender_count, read_gradient, read_follower,
               read_group, read_stamp,
        output ready
    );
endinterface
`default_nettype wire

// ===== rtl/core/ntup_mem.sv =====
// slot memory: one write port, one registered read port
`default_nettype none
module ntup_mem #(
    parameter  int DEPTH = 16,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  ntup_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_waddr,
    input  logic [AW-1:0]     i_raddr,
    input  ntup_pkg::t_entry  i_wdata,
    output ntup_pkg::t_entry  o_rdata
);
    import ntup_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

// ===== rtl/core/ntup_ctrl.sv =====
// sequencer: search, append, purge and read over the slot memory
`default_nettype none
module ntup_ctrl #(
    parameter  int SLOTS = 16,
    localparam int AW    = $clog2(SLOTS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [7:0]          i_cutoff,
    input  logic [7:0]          i_max_age,
    ntup_in_if.sink             i_req,
    ntup_out_if.source          o_rsp,
    output ntup_pkg::t_mem_ctl  o_mem_ctl,
    output logic [AW-1:0]       o_waddr,
    output logic [AW-1:0]       o_raddr,
    output ntup_pkg::t_entry    o_wdata,
    input  ntup_pkg::t_entry    i_rdata,
    output ntup_pkg::t_ctl_stat o_stat
);
    import ntup_pkg::*;

    localparam int XW = (AW > 4) ? AW : 4;
    localparam logic [AW-1:0] LAST = AW'(SLOTS - 1);

    t_state r_state, n_state;

    logic [AW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic          r_cmp_v, n_cmp_v;
    logic [AW-1:0] r_cmp_idx, n_cmp_idx;
    logic          r_stored, n_stored;
    logic [3:0]    r_removed, n_removed;
    logic          r_rd_v, n_rd_v;
    logic          r_ovalid, n_ovalid;
    t_rsp          r_rsp, n_rsp;

    // latched request payload
    logic [15:0] r_id, n_id;
    logic [7:0]  r_dist, n_dist;
    logic [7:0]  r_scount, n_scount;
    logic [15:0] r_grad, n_grad;
    logic [15:0] r_fol, n_fol;
    logic [7:0]  r_grp, n_grp;
    logic [31:0] r_now, n_now;
    logic [3:0]  r_sel, n_sel;

    logic          accept;
    logic          out_free;
    logic          match;
    logic          more;
    logic          table_full;
    logic [31:0]   age;
    logic          aged_out;
    logic [AW-1:0] last_idx;
    logic          is_last;
    logic          idx_zero;
    logic [XW-1:0] sel_x;
    logic          in_range;
    t_entry        new_entry;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && (r_state == S_IDLE);
    assign out_free    = !r_ovalid || o_rsp.ready;

    assign match      = r_cmp_v && (i_rdata.id == r_id);
    assign more       = r_idx < r_count;
    assign table_full = (r_count == LAST);
    assign age        = r_now - i_rdata.stamp;
    assign aged_out   = age > {24'd0, i_max_age};
    assign last_idx   = r_count - 1'b1;
    assign is_last    = (r_idx == last_idx);
    assign idx_zero   = (r_idx == '0);
    assign sel_x      = XW'(r_sel);
    assign in_range   = sel_x < XW'(r_count);

    assign new_entry = '{id: r_id, stamp: r_now, distance: r_dist, sender_count: r_scount,
                         gradient: r_grad, follower: r_fol, grp: r_grp};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    case (i_req.op)
                        OP_MSG:   n_state = (i_req.distance <= i_cutoff) ? S_SEARCH : S_FIN;
                        OP_PURGE: n_state = (r_count == '0) ? S_FIN : S_PURGE_RD;
                        OP_READ:  n_state = S_READ_RD;
                        default:  n_state = S_FIN;
                    endcase
                end
            end
            S_SEARCH: begin
                if (match) begin
                    n_state = S_FIN;
                end else if (!more && !r_cmp_v) begin
                    n_state = S_FIN;
                end
            end
            S_PURGE_RD: n_state = S_PURGE_CHK;
            S_PURGE_CHK: begin
                if (aged_out && !is_last) begin
                    n_state = S_PURGE_MV;
                end else if (idx_zero) begin
                    n_state = S_FIN;
                end
            end
            S_PURGE_MV: n_state = idx_zero ? S_FIN : S_PURGE_CHK;
            S_READ_RD:  n_state = S_FIN;
            S_FIN:      n_state = out_free ? S_IDLE : S_FIN;
            default:    n_state = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp_v   = r_cmp_v;
        n_cmp_idx = r_cmp_idx;
        n_stored  = r_stored;
        n_removed = r_removed;
        n_rd_v    = r_rd_v;
        n_ovalid  = r_ovalid && !o_rsp.ready;
        n_rsp     = r_rsp;
        n_id      = r_id;
        n_dist    = r_dist;
        n_scount  = r_scount;
        n_grad    = r_grad;
        n_fol     = r_fol;
        n_grp     = r_grp;
        n_now     = r_now;
        n_sel     = r_sel;
        o_mem_ctl = '0;
        o_waddr   = r_idx;
        o_raddr   = r_idx;
        o_wdata   = new_entry;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_id      = i_req.sender_id;
                    n_dist    = i_req.distance;
                    n_scount  = i_req.sender_count;
                    n_grad    = i_req.gradient;
                    n_fol     = i_req.follower;
                    n_grp     = i_req.group_byte;
                    n_now     = i_req.now;
                    n_sel     = i_req.slot_index;
                    n_idx     = (i_req.op == OP_PURGE) ? last_idx : '0;
                    n_cmp_v   = 1'b0;
                    n_stored  = 1'b0;
                    n_removed = '0;
                    n_rd_v    = 1'b0;
                end
            end
            S_SEARCH: begin
                // compare happens in the cycle after the read
                if (match) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_waddr         = r_cmp_idx;
                    n_stored        = 1'b1;
                end else if (more) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = r_idx;
                    n_cmp_v         = 1'b1;
                    n_cmp_idx       = r_idx;
                    n_idx           = r_idx + 1'b1;
                end else if (r_cmp_v) begin
                    n_cmp_v = 1'b0;
                end else if (!table_full) begin
                    o_mem_ctl.wr_en = 1'b1;
                    o_waddr         = r_count;
                    n_count         = r_count + 1'b1;
                    n_stored        = 1'b1;
                end
            end
            S_PURGE_RD: begin
                o_mem_ctl.rd_en = 1'b1;
                o_raddr         = r_idx;
            end
            S_PURGE_CHK: begin
                if (aged_out) begin
                    n_removed = r_removed + 4'd1;
                    n_count   = last_idx;
                end
                if (aged_out && !is_last) begin
                    // fetch the last entry to fill the hole
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = last_idx;
                end else if (!idx_zero) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = r_idx - 1'b1;
                    n_idx           = r_idx - 1'b1;
                end
            end
            S_PURGE_MV: begin
                o_mem_ctl.wr_en = 1'b1;
                o_waddr         = r_idx;
                o_wdata         = i_rdata;
                if (!idx_zero) begin
                    o_mem_ctl.rd_en = 1'b1;
                    o_raddr         = r_idx - 1'b1;
                    n_idx           = r_idx - 1'b1;
                end
            end
            S_READ_RD: begin
                o_mem_ctl.rd_en = in_range;
                o_raddr         = sel_x[AW-1:0];
                n_rd_v          = in_range;
            end
            S_FIN: begin
                if (out_free) begin
                    n_ovalid                = 1'b1;
                    n_rsp.entry_count       = 4'(r_count);
                    n_rsp.stored            = r_stored;
                    n_rsp.removed_count     = r_removed;
                    n_rsp.read_valid        = r_rd_v;
                    n_rsp.read_id           = r_rd_v ? i_rdata.id : '0;
                    n_rsp.read_distance     = r_rd_v ? i_rdata.distance : '0;
                    n_rsp.read_sender_count = r_rd_v ? i_rdata.sender_count : '0;
                    n_rsp.read_gradient     = r_rd_v ? i_rdata.gradient : '0;
                    n_rsp.read_follower     = r_rd_v ? i_rdata.follower : '0;
                    n_rsp.read_group        = r_rd_v ? i_rdata.grp : '0;
                    n_rsp.read_stamp        = r_rd_v ? i_rdata.stamp : '0;
                end
            end
            default: begin
                n_ovalid = r_ovalid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_idx     <= '0;
            r_cmp_v   <= 1'b0;
            r_cmp_idx <= '0;
            r_stored  <= 1'b0;
            r_removed <= '0;
            r_rd_v    <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_idx     <= n_idx;
            r_cmp_v   <= n_cmp_v;
            r_cmp_idx <= n_cmp_idx;
            r_stored  <= n_stored;
            r_removed <= n_removed;
            r_rd_v    <= n_rd_v;
            r_ovalid  <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rsp    <= n_rsp;
        r_id     <= n_id;
        r_dist   <= n_dist;
        r_scount <= n_scount;
        r_grad   <= n_grad;
        r_fol    <= n_fol;
        r_grp    <= n_grp;
        r_now    <= n_now;
        r_sel    <= n_sel;
    end

    assign o_rsp.valid             = r_ovalid;
    assign o_rsp.entry_count       = r_rsp.entry_count;
    assign o_rsp.stored            = r_rsp.stored;
    assign o_rsp.removed_count     = r_rsp.removed_count;
    assign o_rsp.read_valid        = r_rsp.read_valid;
    assign o_rsp.read_id           = r_rsp.read_id;
    assign o_rsp.read_distance     = r_rsp.read_distance;
    assign o_rsp.read_sender_count = r_rsp.read_sender_count;
    assign o_rsp.read_gradient     = r_rsp.read_gradient;
    assign o_rsp.read_follower     = r_rsp.read_follower;
    assign o_rsp.read_group        = r_rsp.read_group;
    assign o_rsp.read_stamp        = r_rsp.read_stamp;

    assign o_stat.busy = (r_state != S_IDLE);
    assign o_stat.fin  = (r_state == S_FIN);
endmodule
`default_nettype wire

// ===== rtl/core/neighbor_table_update_purge_top.sv =====
// top level of the neighbour table: config registers, sequencer and slot memory
// one request at a time; message: one slot memory read per compare
// purge: one memory port pair; an empty table goes straight to the response
// read: the result register frees the request side while a response waits
// reset (synchronous, active low): entry count cleared, cutoff 100, max age 64
// slot memory is not cleared; slots above the entry count are never visible
`default_nettype none
`include "neighbor_table_update_purge_top_defines.svh"
module neighbor_table_update_purge_top #(
    parameter int SLOTS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ntup_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]                    i_cfg_wdata,
    ntup_in_if.sink                       i_req,
    ntup_out_if.source                    o_rsp
);
    import ntup_pkg::*;

    localparam int AW = $clog2(SLOTS);

    logic [7:0] r_cutoff;
    logic [7:0] r_max_age;

    t_mem_ctl      w_mem_ctl;
    logic [AW-1:0] w_waddr;
    logic [AW-1:0] w_raddr;
    t_entry        w_wdata;
    t_entry        w_rdata;
    t_ctl_stat     w_stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cutoff  <= CUTOFF_RST;
            r_max_age <= MAX_AGE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CUTOFF:  r_cutoff  <= i_cfg_wdata;
                CFG_MAX_AGE: r_max_age <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ntup_ctrl #(
        .SLOTS(SLOTS)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cutoff  (r_cutoff),
        .i_max_age (r_max_age),
        .i_req     (i_req),
        .o_rsp     (o_rsp),
        .o_mem_ctl (w_mem_ctl),
        .o_waddr   (w_waddr),
        .o_raddr   (w_raddr),
        .o_wdata   (w_wdata),
        .i_rdata   (w_rdata),
        .o_stat    (w_stat)
    );

    ntup_mem #(
        .DEPTH(SLOTS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_ctl   (w_mem_ctl),
        .i_waddr (w_waddr),
        .i_raddr (w_raddr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    `NTUP_ASSERT_NEXT(a_accept_busy, i_req.valid && i_req.ready, w_stat.busy, "request taken but sequencer idle")
    `NTUP_ASSERT_NOW(a_rsp_from_fin, $rose(o_rsp.valid), $past(w_stat.fin), "response raised outside finish")
    `NTUP_ASSERT_NOW(a_rsp_kind, o_rsp.valid, !(o_rsp.read_valid && o_rsp.stored) && !(o_rsp.stored && o_rsp.removed_count != 4'd0) && !(o_rsp.read_valid && o_rsp.removed_count != 4'd0), "response mixes request kinds")
endmodule
`default_nettype wire
